@@ rtl/core/dt2ft_pkg.sv @@
// ----------------------------------------------------------------------------
// dt2ft_pkg
// Shared types, constants and calendar helpers for the date to FILETIME block.
// ----------------------------------------------------------------------------
`default_nettype none

package dt2ft_pkg;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int FT_W     = 58;

  localparam int DAYS_W   = 20;  // whole days since 1601 for any 12-bit year
  localparam int TOD_W    = 17;  // seconds of the day, face-value fields
  localparam int SECS_W   = 37;  // seconds since 1601
  localparam int SPLIT_W  = 20;  // low part of the seconds for the tick multiply
  localparam int TICK_W   = 24;  // width of the ticks-per-second constant
  localparam int SUM_W    = 61;  // full tick count before saturation

  localparam logic [YEAR_W-1:0] EPOCH_YEAR        = 12'd1970;
  localparam logic [DAYS_W-1:0] DAYS_1601_TO_1970 = 20'd134774;
  localparam logic [TOD_W-1:0]  SECONDS_PER_DAY   = 17'd86400;
  localparam logic [TICK_W-1:0] TICKS_PER_SECOND  = 24'd10000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_DATE,
    ST_SCALE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic date;
    logic scale;
    logic mul_lo;
    logic mul_hi;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic loop_done;
  } sts_t;

  // Days before the month, index 0 is January.
  function automatic logic [8:0] days_before_month(input logic [3:0] midx);
    logic [8:0] d;
    unique case (midx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Gregorian leap test; y/100 by reciprocal, exact for any 12-bit y.
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [24:0] prod;
    logic [5:0]  q100;
    logic [12:0] back;
    prod = {13'd0, y} * 25'd5243;
    q100 = prod[24:19];
    back = 13'({7'd0, q100} * 13'd100);
    return (y[1:0] == 2'd0) && ((back != {1'b0, y}) || (q100[1:0] == 2'd0));
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dt2ft_ctrl.sv @@
// ----------------------------------------------------------------------------
// dt2ft_ctrl
// Sequencer: walks the year loop, the date add and the scaling steps, and owns
// both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module dt2ft_ctrl
  import dt2ft_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire  out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.loop_done) begin
          state_nxt = ST_DATE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DATE: begin
        cmd.date  = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        // hold while the previous result still waits
        if (!(out_valid_r && out_stall)) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/core/dt2ft_dp.sv @@
// ----------------------------------------------------------------------------
// dt2ft_dp
// Datapath: day accumulator with year counter, date terms, seconds scaling and
// the split tick multiply with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dt2ft_dp
  import dt2ft_pkg::*;
(
  input  wire                 clk,
  input  wire [YEAR_W-1:0]    in_year,
  input  wire [MONTH_W-1:0]   in_month,
  input  wire [DAY_W-1:0]     in_day,
  input  wire [HOUR_W-1:0]    in_hour,
  input  wire [MINUTE_W-1:0]  in_minute,
  input  wire [SECOND_W-1:0]  in_second,
  output logic [FT_W-1:0]     out_filetime,
  input  cmd_t                cmd,
  output sts_t                sts
);

  logic [YEAR_W-1:0]          year_r;
  logic [MONTH_W-1:0]         month_r;
  logic [DAY_W-1:0]           day_r;
  logic [YEAR_W-1:0]          cur_r;
  logic [DAYS_W-1:0]          days_r;
  logic [TOD_W-1:0]           tod_r;
  logic [SECS_W-1:0]          secs_r;
  logic [SPLIT_W+TICK_W-1:0]  plo_r;
  logic [SECS_W-SPLIT_W+TICK_W-1:0] phi_r;
  logic [FT_W-1:0]            ft_r;

  logic [TOD_W-1:0]           tod_nxt;
  logic [3:0]                 midx;
  logic [DAYS_W-1:0]          date_days;
  logic [SUM_W-1:0]           total;

  always_comb begin
    tod_nxt = TOD_W'(in_hour) * 17'd3600 + TOD_W'(in_minute) * 17'd60 + TOD_W'(in_second);
  end

  always_comb begin
    midx = ((month_r >= 4'd1) && (month_r <= 4'd12)) ? (month_r - 4'd1) : 4'd0;
    date_days = days_r + DAYS_W'(days_before_month(midx)) + DAYS_1601_TO_1970
              + DAYS_W'((midx >= 4'd2) && leap_year(year_r))
              + DAYS_W'((day_r != '0) ? (day_r - 5'd1) : 5'd0);
  end

  always_comb begin
    total = {phi_r, {SPLIT_W{1'b0}}} + SUM_W'(plo_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r  <= in_year;
      month_r <= in_month;
      day_r   <= in_day;
      cur_r   <= EPOCH_YEAR;
      days_r  <= '0;
      tod_r   <= tod_nxt;
    end
    if (cmd.step) begin
      // advance one whole year
      days_r <= days_r + (leap_year(cur_r) ? 20'd366 : 20'd365);
      cur_r  <= cur_r + 12'd1;
    end
    if (cmd.date) begin
      days_r <= date_days;
    end
    if (cmd.scale) begin
      secs_r <= SECS_W'(days_r) * SECS_W'(SECONDS_PER_DAY) + SECS_W'(tod_r);
    end
    if (cmd.mul_lo) begin
      plo_r <= (SPLIT_W+TICK_W)'(secs_r[SPLIT_W-1:0]) * (SPLIT_W+TICK_W)'(TICKS_PER_SECOND);
    end
    if (cmd.mul_hi) begin
      phi_r <= (SECS_W-SPLIT_W+TICK_W)'(secs_r[SECS_W-1:SPLIT_W])
             * (SECS_W-SPLIT_W+TICK_W)'(TICKS_PER_SECOND);
    end
    if (cmd.emit) begin
      // clamp counts that overflow the result width
      ft_r <= (total[SUM_W-1:FT_W] != '0) ? {FT_W{1'b1}} : total[FT_W-1:0];
    end
  end

  assign sts.loop_done = (cur_r >= year_r);
  assign out_filetime  = ft_r;

endmodule

`default_nettype wire

@@ rtl/core/datetime_to_filetime.sv @@
// ----------------------------------------------------------------------------
// datetime_to_filetime
// Converts one calendar reading (year, month, day, hour, minute, second) to a
// 58-bit count of 100-ns ticks since 1601-01-01 UTC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction carries a full reading. Result
//   channel out_*: one transaction per input, in order. Both use valid/stall.
//   Sequence: the year loop adds one year's days per cycle, from 1970 up
//   to the input year (no steps for years up to 1970); then come the date
//   add, seconds scaling, two tick half-multiplies and the final sum, in
//   that order, before out_valid rises.
//   Throughput: one transaction at a time; in_stall is high from acceptance
//   until the result is loaded into the output register. A new reading is
//   taken while a finished result still waits on out_stall.
//   Receiver stall: the result holds in the output register; a following
//   conversion completes and waits in its last step until the register frees.
//   Reset (rst_n low, synchronous): the sequencer returns to idle and
//   out_valid drops; any conversion in flight is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module datetime_to_filetime
  import dt2ft_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [YEAR_W-1:0]    in_year,
  input  wire [MONTH_W-1:0]   in_month,
  input  wire [DAY_W-1:0]     in_day,
  input  wire [HOUR_W-1:0]    in_hour,
  input  wire [MINUTE_W-1:0]  in_minute,
  input  wire [SECOND_W-1:0]  in_second,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [FT_W-1:0]     out_filetime
);

  cmd_t cmd;
  sts_t sts;

  dt2ft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dt2ft_dp u_dp (
    .clk          (clk),
    .in_year      (in_year),
    .in_month     (in_month),
    .in_day       (in_day),
    .in_hour      (in_hour),
    .in_minute    (in_minute),
    .in_second    (in_second),
    .out_filetime (out_filetime),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

`default_nettype wire

@@ tb/dt2ft_checker.sv @@
// ----------------------------------------------------------------------------
// dt2ft_checker
// Watches both channels of the date to FILETIME block, predicts the tick
// count of every accepted reading and compares it with the returned result.
// ----------------------------------------------------------------------------
module dt2ft_checker
  import dt2ft_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  wire [YEAR_W-1:0]    in_year,
  input  wire [MONTH_W-1:0]   in_month,
  input  wire [DAY_W-1:0]     in_day,
  input  wire [HOUR_W-1:0]    in_hour,
  input  wire [MINUTE_W-1:0]  in_minute,
  input  wire [SECOND_W-1:0]  in_second,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  wire [FT_W-1:0]      out_filetime,
  output int                  mismatch_count,
  output int                  pending_count
);

  localparam longint unsigned UNIX_YEAR     = 1970;
  localparam longint unsigned EPOCH_DAYS    = 134774;
  localparam longint unsigned DAY_SECONDS   = 86400;
  localparam longint unsigned TICKS_PER_SEC = 10000000;
  localparam longint unsigned TICK_CEILING  = (64'd1 << FT_W) - 1;

  localparam int unsigned CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243,
                                            273, 304, 334};

  logic [FT_W-1:0] filetime_queue [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  // Leap years in 1..n.
  function automatic longint unsigned leaps_upto(input longint unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic logic [FT_W-1:0] filetime_of(
    input logic [YEAR_W-1:0]   year,
    input logic [MONTH_W-1:0]  month,
    input logic [DAY_W-1:0]    day,
    input logic [HOUR_W-1:0]   hour,
    input logic [MINUTE_W-1:0] minute,
    input logic [SECOND_W-1:0] second
  );
    longint unsigned yr;
    longint unsigned days;
    longint unsigned secs;
    longint unsigned ticks;
    int unsigned     midx;
    logic            leap;
    yr   = longint'(year);
    days = 0;
    if (yr > UNIX_YEAR) begin
      days = 365 * (yr - UNIX_YEAR) + leaps_upto(yr - 1) - leaps_upto(UNIX_YEAR - 1);
    end
    // Out-of-range months count as January.
    midx = (month >= 1 && month <= 12) ? int'(month) - 1 : 0;
    days += CUM_DAYS[midx];
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (midx >= 2 && leap) begin
      days += 1;
    end
    if (day != 0) begin
      days += longint'(day) - 1;
    end
    days += EPOCH_DAYS;
    secs = days * DAY_SECONDS + longint'(hour) * 3600 + longint'(minute) * 60
         + longint'(second);
    ticks = secs * TICKS_PER_SEC;
    if (ticks > TICK_CEILING) begin
      ticks = TICK_CEILING;
    end
    return ticks[FT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (filetime_queue.size() == 0) begin
          $display("%0t: unexpected result transaction, filetime %0d", $time, out_filetime);
          mismatch_count++;
        end else begin
          if (out_filetime !== filetime_queue[0]) begin
            $display("%0t: filetime mismatch, expected %0d, actual %0d", $time,
                     filetime_queue[0], out_filetime);
            mismatch_count++;
          end
          void'(filetime_queue.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        filetime_queue.push_back(filetime_of(in_year, in_month, in_day, in_hour,
                                             in_minute, in_second));
      end
      pending_count = filetime_queue.size();
    end
  end

endmodule

@@ tb/datetime_to_filetime_tb.sv @@
// ----------------------------------------------------------------------------
// datetime_to_filetime_tb
// Drives calendar readings into the date to FILETIME block under random
// sender and receiver idling, with one long receiver hold-off; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module datetime_to_filetime_tb
  import dt2ft_pkg::*;
();

  localparam int RANDOM_PER_PHASE = 383;
  localparam int HOLD_CYCLES      = 1500;
  localparam int DRAIN_CYCLES     = 2200;
  localparam int WATCHDOG_LIMIT   = 20000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [YEAR_W-1:0]   in_year;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic [HOUR_W-1:0]   in_hour;
  logic [MINUTE_W-1:0] in_minute;
  logic [SECOND_W-1:0] in_second;
  logic                out_valid;
  logic                out_stall;
  logic [FT_W-1:0]     out_filetime;

  int mismatch_count;
  int pending_count;
  int phase;
  int send_idle_pct;
  int recv_idle_pct;

  datetime_to_filetime DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_year      (in_year),
    .in_month     (in_month),
    .in_day       (in_day),
    .in_hour      (in_hour),
    .in_minute    (in_minute),
    .in_second    (in_second),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filetime (out_filetime)
  );

  dt2ft_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_hour        (in_hour),
    .in_minute      (in_minute),
    .in_second      (in_second),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_filetime   (out_filetime),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Present one reading and hold it until the block takes it.
  task automatic offer_reading(input int year, input int month, input int day,
                               input int hour, input int minute, input int second);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_year   = YEAR_W'(year);
    in_month  = MONTH_W'(month);
    in_day    = DAY_W'(day);
    in_hour   = HOUR_W'(hour);
    in_minute = MINUTE_W'(minute);
    in_second = SECOND_W'(second);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic random_reading();
    int year;
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      // Well-formed reading, mostly in the nominal year span.
      year = (pick < 80) ? $urandom_range(1970, 2399) : $urandom_range(2400, 2600);
      offer_reading(year, $urandom_range(1, 12), $urandom_range(1, 31),
                    $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 60));
    end else begin
      year = (pick < 93) ? $urandom_range(0, 1970) : $urandom_range(0, (1 << YEAR_W) - 1);
      offer_reading(year, $urandom_range(0, 15), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  // Receiver: random stall, plus one long hold-off when the first random phase starts.
  initial begin
    int seen_phase;
    int hold_left;
    seen_phase = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (phase != seen_phase) begin
        seen_phase = phase;
        if (phase == 1) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("datetime_to_filetime_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_year       = '0;
    in_month      = '0;
    in_day        = '0;
    in_hour       = '0;
    in_minute     = '0;
    in_second     = '0;
    phase         = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed readings: epoch, field extremes, leap rules, odd months and days.
    offer_reading(1970, 1, 1, 0, 0, 0);
    offer_reading(1970, 0, 0, 0, 0, 0);
    offer_reading(0, 0, 0, 0, 0, 0);
    offer_reading(4095, 15, 31, 31, 63, 63);
    offer_reading(1968, 3, 1, 0, 0, 0);
    offer_reading(1969, 12, 31, 23, 59, 59);
    offer_reading(2000, 2, 29, 23, 59, 59);
    offer_reading(2000, 3, 1, 0, 0, 0);
    offer_reading(2100, 3, 1, 0, 0, 0);
    offer_reading(2400, 3, 1, 0, 0, 0);
    offer_reading(2399, 12, 31, 23, 59, 60);
    offer_reading(2016, 13, 0, 12, 30, 30);
    offer_reading(2016, 15, 31, 31, 63, 63);
    for (int m = 1; m <= 12; m++) begin
      offer_reading(2020, m, m + 17, m, m * 5, m * 4);
    end

    for (int p = 1; p <= 3; p++) begin
      phase         = p;
      send_idle_pct = (p == 1) ? 22 : (p == 2) ? 71 : 0;
      recv_idle_pct = (p == 1) ? 71 : (p == 2) ? 22 : 0;
      repeat (RANDOM_PER_PHASE) random_reading();
    end
    in_valid = 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("datetime_to_filetime_tb: clean");
    end else begin
      $display("datetime_to_filetime_tb: errors");
    end
    $finish;
  end

endmodule
